FILE: hdl/tkf_pkg.sv
package tkf_pkg;

    localparam int FRAC_W    = 24;
    localparam int NUM_AXES  = 3;
    localparam int AXIS_W    = 2;
    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

    // bit-serial multiplier: signed a (wide side) times signed b (scanned side)
    localparam int MUL_A_W   = 36;
    localparam int MUL_B_W   = 32;
    localparam int MUL_ACC_W = MUL_A_W - 1 + MUL_B_W;
    localparam int MUL_RND_W = MUL_ACC_W - FRAC_W + 1;
    localparam int MUL_P_W   = MUL_RND_W + 1;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // bit-serial restoring divider: (num << FRAC_W) / den
    localparam int DIV_N_W   = 32;
    localparam int DIV_D_W   = 33;
    localparam int DIV_SH_W  = DIV_N_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_SH_W);

    localparam int CFG_W = 24;
    localparam logic [CFG_W-1:0] QA_RESET = 24'd16777;
    localparam logic [CFG_W-1:0] QB_RESET = 24'd50332;
    localparam logic [CFG_W-1:0] R_RESET  = 24'd503316;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_QA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE,
        ST_WAIT,
        ST_STORE,
        ST_PUSH
    } state_t;

    typedef enum logic [3:0] {
        STP_ANG_PRED,
        STP_M,
        STP_P00,
        STP_P11,
        STP_K0,
        STP_K1,
        STP_ANG_UPD,
        STP_BIAS_UPD,
        STP_C10,
        STP_C00,
        STP_C11,
        STP_C01
    } step_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v[47:31] == {17{v[47]}})
        begin
            return v[31:0];
        end
        else if (v[47])
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

FILE: hdl/tkf_mul.sv
// Shift-add multiplier, one bit of b per cycle, result rounded by 2^-24
// (nearest, ties away from zero).
module tkf_mul (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [tkf_pkg::MUL_A_W-1:0]      a,
    input  logic signed [tkf_pkg::MUL_B_W-1:0]      b,
    output logic                                    done,
    output logic signed [tkf_pkg::MUL_P_W-1:0]      prod
);
    localparam int MAG_A_W = tkf_pkg::MUL_A_W - 1;
    localparam int B_W     = tkf_pkg::MUL_B_W;
    localparam int ACC_W   = tkf_pkg::MUL_ACC_W;
    localparam int RND_W   = tkf_pkg::MUL_RND_W;
    localparam int CNT_W   = tkf_pkg::MUL_CNT_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(B_W - 1);

    logic                       busy_reg;
    logic                       rnd_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [MAG_A_W-1:0]         mag_a_reg;
    logic [B_W-1:0]             mag_b_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic                       neg_reg;
    logic signed [tkf_pkg::MUL_P_W-1:0] prod_reg;

    logic [tkf_pkg::MUL_A_W-1:0] a_neg;
    logic [MAG_A_W-1:0]         mag_a_in;
    logic [B_W-1:0]             mag_b_in;
    logic [MAG_A_W-1:0]         part;
    logic [MAG_A_W:0]           sum;
    logic [ACC_W-1:0]           acc_next;
    logic [RND_W-1:0]           rnd_mag;

    always_comb
    begin
        a_neg    = -a;
        mag_a_in = a[tkf_pkg::MUL_A_W-1] ? a_neg[MAG_A_W-1:0] : a[MAG_A_W-1:0];
        mag_b_in = b[B_W-1] ? (~b + B_W'(1)) : b;
        part     = mag_b_reg[0] ? mag_a_reg : '0;
        sum      = {1'b0, acc_reg[ACC_W-1:B_W]} + {1'b0, part};
        acc_next = {sum, acc_reg[B_W-1:1]};
        rnd_mag  = {1'b0, acc_reg[ACC_W-1:tkf_pkg::FRAC_W]}
                 + {{(RND_W-1){1'b0}}, acc_reg[tkf_pkg::FRAC_W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    rnd_reg  <= 1'b1;
                end
            end
            else if (rnd_reg)
            begin
                rnd_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_a_reg <= mag_a_in;
            mag_b_reg <= mag_b_in;
            neg_reg   <= a[tkf_pkg::MUL_A_W-1] ^ b[B_W-1];
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg   <= acc_next;
            mag_b_reg <= mag_b_reg >> 1;
        end
        else if (rnd_reg)
        begin
            prod_reg <= neg_reg ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

FILE: hdl/tkf_div.sv
// Restoring divider, one quotient bit per cycle: sat32((num << 24) / den),
// truncated toward zero; zero when den is zero.
module tkf_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tkf_pkg::DIV_N_W-1:0]  num,
    input  logic signed [tkf_pkg::DIV_D_W-1:0]  den,
    output logic                                done,
    output logic signed [tkf_pkg::DIV_N_W-1:0]  quo
);
    localparam int N_W   = tkf_pkg::DIV_N_W;
    localparam int D_W   = tkf_pkg::DIV_D_W;
    localparam int SH_W  = tkf_pkg::DIV_SH_W;
    localparam int CNT_W = tkf_pkg::DIV_CNT_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SH_W - 1);

    logic                   busy_reg;
    logic                   fin_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SH_W-1:0]        sh_reg;
    logic [D_W-1:0]         dmag_reg;
    logic [D_W-1:0]         rem_reg;
    logic [N_W:0]           q_reg;
    logic                   ovf_reg;
    logic                   neg_reg;
    logic                   zero_reg;
    logic signed [N_W-1:0]  quo_reg;

    logic [N_W-1:0]         nmag_in;
    logic [D_W-1:0]         dmag_in;
    logic [D_W:0]           trial;
    logic [D_W:0]           diff;
    logic                   ge;
    logic                   big;

    always_comb
    begin
        nmag_in = num[N_W-1] ? (~num + N_W'(1)) : num;
        dmag_in = den[D_W-1] ? (~den + D_W'(1)) : den;
        trial   = {rem_reg, sh_reg[SH_W-1]};
        diff    = trial - {1'b0, dmag_reg};
        ge      = trial >= {1'b0, dmag_reg};
        big     = ovf_reg | q_reg[N_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg   <= {nmag_in, {tkf_pkg::FRAC_W{1'b0}}};
            dmag_reg <= dmag_in;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            neg_reg  <= num[N_W-1] ^ den[D_W-1];
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_reg << 1;
            rem_reg <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            q_reg   <= {q_reg[N_W-1:0], ge};
            ovf_reg <= ovf_reg | q_reg[N_W];
        end
        else if (fin_reg)
        begin
            if (zero_reg)
            begin
                quo_reg <= '0;
            end
            else if (neg_reg)
            begin
                // magnitude above 2^31 clamps to the most negative value
                quo_reg <= (big || (q_reg[N_W-1] && (q_reg[N_W-2:0] != '0)))
                         ? {1'b1, {(N_W-1){1'b0}}} : -$signed(q_reg[N_W-1:0]);
            end
            else
            begin
                quo_reg <= (big || q_reg[N_W-1]) ? {1'b0, {(N_W-1){1'b1}}}
                                                 : $signed(q_reg[N_W-1:0]);
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: hdl/tilt_kalman_filter_three_axis_unit.sv
// Three-axis tilt filter: one angle / gyro-bias Kalman filter per axis.
// Input channel (in_valid/in_ready): a request carries three measured angles,
// three gyro rates (Q16.16) and the time step (Q0.24). Output channel
// (out_valid/out_ready): one request per input with three filtered angles and
// three biases (Q16.16, saturating).
// Config port: cfg_we/cfg_index/cfg_data writes Qa (0), Qb (1), R (2); other
// indexes are ignored. Write only while the block is idle.
// Axes run one after another through a shared bit-serial multiplier (ten
// products per axis) and a shared bit-serial divider (two gains per axis).
// One request is processed at a time; in_ready rises again at the same edge
// that loads the result into the output register, so a new request is only
// accepted once the previous one has been pushed.
// A finished result sits in the output register; the next request may be
// accepted and processed while it waits. If the previous result is still not
// taken when the next one finishes, the sequencer holds in its push state.
// Reset clears estimates and covariance to zero, restores the noise
// registers to their defaults and empties the output register.
module tilt_kalman_filter_three_axis_unit (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [24:0]  meas_angle_x,
    input  logic signed [24:0]  meas_angle_y,
    input  logic signed [24:0]  meas_angle_z,
    input  logic signed [28:0]  rate_x,
    input  logic signed [28:0]  rate_y,
    input  logic signed [28:0]  rate_z,
    input  logic [23:0]         time_step,

    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  angle_x,
    output logic signed [31:0]  angle_y,
    output logic signed [31:0]  angle_z,
    output logic signed [31:0]  bias_x,
    output logic signed [31:0]  bias_y,
    output logic signed [31:0]  bias_z,

    input  logic                                cfg_we,
    input  logic [tkf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tkf_pkg::CFG_W-1:0]           cfg_data
);
    localparam int AW = tkf_pkg::AXIS_W;
    localparam int NA = tkf_pkg::NUM_AXES;

    // sequencer
    tkf_pkg::state_t    state_reg, state_next;
    tkf_pkg::step_t     step_reg;
    logic [AW-1:0]      axis_reg;

    // noise settings
    logic [tkf_pkg::CFG_W-1:0] qa_reg, qb_reg, r_reg;

    // filter state per axis
    logic signed [31:0] ang_reg  [NA];
    logic signed [31:0] bias_reg [NA];
    logic signed [31:0] p00_reg  [NA];
    logic signed [31:0] p01_reg  [NA];
    logic signed [31:0] p10_reg  [NA];
    logic signed [31:0] p11_reg  [NA];

    // latched request
    logic signed [24:0] meas_reg [NA];
    logic signed [28:0] rate_reg [NA];
    logic [23:0]        dt_reg;

    // working copy of the current axis
    logic signed [31:0] w_ang, w_bias, w_p00, w_p01, w_p10, w_p11;
    logic signed [32:0] w_m;
    logic signed [31:0] w_k0, w_k1, w_y;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] ang_out_reg  [NA];
    logic signed [31:0] bias_out_reg [NA];

    // control decoded from state
    logic               mul_start, div_start, push_en, unit_done, step_is_div;
    logic               last_step;

    // shared arithmetic units
    logic signed [tkf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tkf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [tkf_pkg::MUL_P_W-1:0] mul_prod;
    logic                               mul_done;
    logic signed [tkf_pkg::DIV_N_W-1:0] div_num;
    logic signed [tkf_pkg::DIV_D_W-1:0] div_den;
    logic signed [tkf_pkg::DIV_N_W-1:0] div_quo;
    logic                               div_done;

    logic signed [24:0] meas_cur;
    logic signed [28:0] rate_cur;
    logic signed [47:0] prod_x;

    tkf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tkf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tkf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tkf_pkg::ST_LOAD;
                end
            end
            tkf_pkg::ST_LOAD:
            begin
                state_next = tkf_pkg::ST_ISSUE;
            end
            tkf_pkg::ST_ISSUE:
            begin
                state_next = tkf_pkg::ST_WAIT;
            end
            tkf_pkg::ST_WAIT:
            begin
                if (unit_done)
                begin
                    state_next = last_step ? tkf_pkg::ST_STORE : tkf_pkg::ST_ISSUE;
                end
            end
            tkf_pkg::ST_STORE:
            begin
                state_next = (axis_reg == tkf_pkg::LAST_AXIS) ? tkf_pkg::ST_PUSH
                                                              : tkf_pkg::ST_LOAD;
            end
            tkf_pkg::ST_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = tkf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tkf_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // state outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        push_en   = 1'b0;
        case (state_reg)
            tkf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            tkf_pkg::ST_ISSUE:
            begin
                mul_start = !step_is_div;
                div_start = step_is_div;
            end
            tkf_pkg::ST_PUSH:
            begin
                push_en = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign step_is_div = (step_reg == tkf_pkg::STP_K0) || (step_reg == tkf_pkg::STP_K1);
    assign last_step   = (step_reg == tkf_pkg::STP_C01);
    assign unit_done   = step_is_div ? div_done : mul_done;

    // ---------------------------------------------------------------
    // operand selection
    // ---------------------------------------------------------------
    always_comb
    begin
        meas_cur = meas_reg[axis_reg];
        rate_cur = rate_reg[axis_reg];
        mul_a    = '0;
        mul_b    = {8'b0, dt_reg};
        case (step_reg)
            tkf_pkg::STP_ANG_PRED:
            begin
                mul_a = {{7{rate_cur[28]}}, rate_cur} - {{4{w_bias[31]}}, w_bias};
            end
            tkf_pkg::STP_M:
            begin
                mul_a = {{4{w_p11[31]}}, w_p11};
            end
            tkf_pkg::STP_P00:
            begin
                mul_a = {{3{w_m[32]}}, w_m} - {{4{w_p01[31]}}, w_p01}
                      - {{4{w_p10[31]}}, w_p10} + {12'b0, qa_reg};
            end
            tkf_pkg::STP_P11:
            begin
                mul_a = {12'b0, qb_reg};
            end
            tkf_pkg::STP_ANG_UPD:
            begin
                mul_a = {{4{w_y[31]}}, w_y};
                mul_b = w_k0;
            end
            tkf_pkg::STP_BIAS_UPD:
            begin
                mul_a = {{4{w_y[31]}}, w_y};
                mul_b = w_k1;
            end
            tkf_pkg::STP_C10:
            begin
                mul_a = {{4{w_p00[31]}}, w_p00};
                mul_b = w_k1;
            end
            tkf_pkg::STP_C00:
            begin
                mul_a = {{4{w_p00[31]}}, w_p00};
                mul_b = w_k0;
            end
            tkf_pkg::STP_C11:
            begin
                mul_a = {{4{w_p01[31]}}, w_p01};
                mul_b = w_k1;
            end
            tkf_pkg::STP_C01:
            begin
                mul_a = {{4{w_p01[31]}}, w_p01};
                mul_b = w_k0;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        // S = P00 + R, gains share it
        div_den = {w_p00[31], w_p00} + {9'b0, r_reg};
        div_num = (step_reg == tkf_pkg::STP_K0) ? w_p00 : w_p10;
        prod_x  = {{3{mul_prod[tkf_pkg::MUL_P_W-1]}}, mul_prod};
    end

    // ---------------------------------------------------------------
    // control registers, configuration and filter state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkf_pkg::ST_IDLE;
            step_reg      <= tkf_pkg::STP_ANG_PRED;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            qa_reg        <= tkf_pkg::QA_RESET;
            qb_reg        <= tkf_pkg::QB_RESET;
            r_reg         <= tkf_pkg::R_RESET;
            for (int i = 0; i < NA; i++)
            begin
                ang_reg[i]  <= '0;
                bias_reg[i] <= '0;
                p00_reg[i]  <= '0;
                p01_reg[i]  <= '0;
                p10_reg[i]  <= '0;
                p11_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    tkf_pkg::REG_QA: qa_reg <= cfg_data;
                    tkf_pkg::REG_QB: qb_reg <= cfg_data;
                    tkf_pkg::REG_R:  r_reg  <= cfg_data;
                    default:         qa_reg <= qa_reg;
                endcase
            end

            if (state_reg == tkf_pkg::ST_IDLE && in_valid)
            begin
                axis_reg <= '0;
            end

            if (state_reg == tkf_pkg::ST_LOAD)
            begin
                step_reg <= tkf_pkg::STP_ANG_PRED;
            end
            else if (state_reg == tkf_pkg::ST_WAIT && unit_done && !last_step)
            begin
                step_reg <= tkf_pkg::step_t'(step_reg + 4'd1);
            end

            if (state_reg == tkf_pkg::ST_STORE)
            begin
                ang_reg[axis_reg]  <= w_ang;
                bias_reg[axis_reg] <= w_bias;
                p00_reg[axis_reg]  <= w_p00;
                p01_reg[axis_reg]  <= w_p01;
                p10_reg[axis_reg]  <= w_p10;
                p11_reg[axis_reg]  <= w_p11;
                if (axis_reg != tkf_pkg::LAST_AXIS)
                begin
                    axis_reg <= axis_reg + AW'(1);
                end
            end

            if (push_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == tkf_pkg::ST_IDLE && in_valid)
        begin
            meas_reg[0] <= meas_angle_x;
            meas_reg[1] <= meas_angle_y;
            meas_reg[2] <= meas_angle_z;
            rate_reg[0] <= rate_x;
            rate_reg[1] <= rate_y;
            rate_reg[2] <= rate_z;
            dt_reg      <= time_step;
        end

        if (state_reg == tkf_pkg::ST_LOAD)
        begin
            w_ang  <= ang_reg[axis_reg];
            w_bias <= bias_reg[axis_reg];
            w_p00  <= p00_reg[axis_reg];
            w_p01  <= p01_reg[axis_reg];
            w_p10  <= p10_reg[axis_reg];
            w_p11  <= p11_reg[axis_reg];
        end
        else if (state_reg == tkf_pkg::ST_WAIT && unit_done)
        begin
            case (step_reg)
                tkf_pkg::STP_ANG_PRED:
                begin
                    w_ang <= tkf_pkg::sat32({{16{w_ang[31]}}, w_ang} + prod_x);
                end
                tkf_pkg::STP_M:
                begin
                    w_m <= mul_prod[32:0];
                end
                tkf_pkg::STP_P00:
                begin
                    w_p00 <= tkf_pkg::sat32({{16{w_p00[31]}}, w_p00} + prod_x);
                    w_p01 <= tkf_pkg::sat32({{16{w_p01[31]}}, w_p01}
                                            - {{15{w_m[32]}}, w_m});
                    w_p10 <= tkf_pkg::sat32({{16{w_p10[31]}}, w_p10}
                                            - {{15{w_m[32]}}, w_m});
                end
                tkf_pkg::STP_P11:
                begin
                    w_p11 <= tkf_pkg::sat32({{16{w_p11[31]}}, w_p11} + prod_x);
                end
                tkf_pkg::STP_K0:
                begin
                    w_k0 <= div_quo;
                end
                tkf_pkg::STP_K1:
                begin
                    w_k1 <= div_quo;
                    // innovation against the predicted angle
                    w_y  <= tkf_pkg::sat32({{23{meas_cur[24]}}, meas_cur}
                                           - {{16{w_ang[31]}}, w_ang});
                end
                tkf_pkg::STP_ANG_UPD:
                begin
                    w_ang <= tkf_pkg::sat32({{16{w_ang[31]}}, w_ang} + prod_x);
                end
                tkf_pkg::STP_BIAS_UPD:
                begin
                    w_bias <= tkf_pkg::sat32({{16{w_bias[31]}}, w_bias} + prod_x);
                end
                // P10 and P11 first: they need P00 and P01 before their update
                tkf_pkg::STP_C10:
                begin
                    w_p10 <= tkf_pkg::sat32({{16{w_p10[31]}}, w_p10} - prod_x);
                end
                tkf_pkg::STP_C00:
                begin
                    w_p00 <= tkf_pkg::sat32({{16{w_p00[31]}}, w_p00} - prod_x);
                end
                tkf_pkg::STP_C11:
                begin
                    w_p11 <= tkf_pkg::sat32({{16{w_p11[31]}}, w_p11} - prod_x);
                end
                tkf_pkg::STP_C01:
                begin
                    w_p01 <= tkf_pkg::sat32({{16{w_p01[31]}}, w_p01} - prod_x);
                end
                default:
                begin
                    w_m <= w_m;
                end
            endcase
        end

        if (push_en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                ang_out_reg[i]  <= ang_reg[i];
                bias_out_reg[i] <= bias_reg[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign angle_x   = ang_out_reg[0];
    assign angle_y   = ang_out_reg[1];
    assign angle_z   = ang_out_reg[2];
    assign bias_x    = bias_out_reg[0];
    assign bias_y    = bias_out_reg[1];
    assign bias_z    = bias_out_reg[2];

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg <= tkf_pkg::LAST_AXIS)
        else $error("axis counter out of range");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_done || div_done) |-> (state_reg == tkf_pkg::ST_WAIT))
        else $error("arithmetic unit finished outside wait state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == tkf_pkg::ST_LOAD && axis_reg == '0))
        else $error("request accepted but axis sweep not started");

    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |=> (out_valid_reg && state_reg == tkf_pkg::ST_IDLE))
        else $error("result push did not raise out_valid");

endmodule
